// ===== sv/gac_pkg.sv =====
// Shared widths, types and codes for the greedy affinity clustering block.
package gac_pkg;
    localparam int THR_W     = 5;
    localparam int RATE_W    = 16;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_RUN   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THREADS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd2;

    typedef logic [THR_W-1:0]     thread_t;
    typedef logic [RATE_W-1:0]    rate_t;
    typedef logic [CFG_W-1:0]     cfg_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
endpackage

// ===== sv/gac_if.sv =====
// Valid/ready channel interfaces for command words and result words.
interface gac_item_if import gac_pkg::*;;
    logic    valid;
    logic    ready;
    logic    command;
    thread_t row_thread;
    thread_t col_thread;
    rate_t   rate_value;

    modport source (output valid, command, row_thread, col_thread, rate_value, input ready);
    modport sink   (input valid, command, row_thread, col_thread, rate_value, output ready);
endinterface

interface gac_result_if import gac_pkg::*;;
    logic    valid;
    logic    ready;
    thread_t group_ordinal;
    thread_t member_thread;
    logic    last_member;

    modport source (output valid, group_ordinal, member_thread, last_member, input ready);
    modport sink   (input valid, group_ordinal, member_thread, last_member, output ready);
endinterface

// ===== sv/greedy_affinity_clustering.sv =====
// Greedy affinity clustering of threads over a rate matrix held in on-chip memory.
// A write word stores one matrix entry. A run word clusters the first
// thread_count threads and then emits one result word per thread, grouped by final
// group in slot order. A run places each thread in its own group; then, per round and
// per pairing, it scans the first n slots and scores every candidate over its member
// pairs (member read, rate read, accumulate), copying members on a merge. Each result
// word is then read, loaded and held until the sink takes it. No new word is taken
// until the last result word of a run has been delivered.
module greedy_affinity_clustering import gac_pkg::*; #(
    parameter int MAX_THREADS = 32,
    parameter int RATE_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    gac_item_if.sink     item_in,
    gac_result_if.source result_out,
    input  logic         cfg_we,
    input  cfg_idx_t     cfg_index,
    input  cfg_t         cfg_data
);
    localparam int IDX_W = $clog2(MAX_THREADS);
    localparam int CNT_W = $clog2(MAX_THREADS + 1);
    localparam int AW    = $clog2(MAX_THREADS * MAX_THREADS);
    localparam int ACC_W = RATE_BITS + 2 * IDX_W;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_INIT     = 5'd1;
    localparam logic [4:0] S_ROUND    = 5'd2;
    localparam logic [4:0] S_PICK     = 5'd3;
    localparam logic [4:0] S_SCAN     = 5'd4;
    localparam logic [4:0] S_AFF_RD   = 5'd5;
    localparam logic [4:0] S_AFF_RT   = 5'd6;
    localparam logic [4:0] S_AFF_ACC  = 5'd7;
    localparam logic [4:0] S_MERGE    = 5'd8;
    localparam logic [4:0] S_CP_RD    = 5'd9;
    localparam logic [4:0] S_CP_WR    = 5'd10;
    localparam logic [4:0] S_MFIN     = 5'd11;
    localparam logic [4:0] S_REVIVE   = 5'd12;
    localparam logic [4:0] S_OUT_NEXT = 5'd13;
    localparam logic [4:0] S_OUT_RD   = 5'd14;
    localparam logic [4:0] S_OUT_LOAD = 5'd15;
    localparam logic [4:0] S_OUT_WAIT = 5'd16;

    // config
    cfg_t target_reg, threads_reg;
    logic mode_reg;

    logic [4:0]             state_reg, state_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic [CNT_W-1:0]       vg_reg, vg_next;
    logic [CNT_W-1:0]       reuse_cnt_reg, reuse_cnt_next;
    logic [MAX_THREADS-1:0] valid_reg, valid_next;
    logic [MAX_THREADS-1:0] reuse_reg, reuse_next;
    logic [CNT_W-1:0]       size_reg [MAX_THREADS];
    logic [CNT_W-1:0]       size_next [MAX_THREADS];
    logic [CNT_W-1:0]       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IDX_W-1:0]       a_reg, a_next, b_reg, b_next, last_g_reg, last_g_next;
    logic [CNT_W-1:0]       size_a_reg, size_a_next, size_k_reg, size_k_next;
    logic [CNT_W-1:0]       size_b_reg, size_b_next, ord_reg, ord_next;
    logic [ACC_W-1:0]       acc_reg, acc_next, best_reg, best_next;
    logic                   got_b_reg, got_b_next;
    logic                   out_valid_reg, out_valid_next;
    thread_t                out_ord_reg, out_ord_next, out_mem_reg, out_mem_next;
    logic                   out_last_reg, out_last_next;

    // memories
    logic [RATE_BITS-1:0] rate_mem [MAX_THREADS*MAX_THREADS];
    logic [IDX_W-1:0]     memb_mem [MAX_THREADS*MAX_THREADS];
    logic                 rate_we, memb_we;
    logic [AW-1:0]        rate_wa, rate_ra, memb_wa, memb_ra0, memb_ra1;
    logic [RATE_BITS-1:0] rate_wd, rate_rd;
    logic [IDX_W-1:0]     memb_wd, memb_rd0, memb_rd1;

    logic                 first_found;
    logic [IDX_W-1:0]     first_idx, high_idx;
    logic [CNT_W-1:0]     n_eff;
    logic [ACC_W-1:0]     acc_new;
    logic [31:0]          tgt_eff, tot_size;

    assign item_in.ready            = (state_reg == S_IDLE);
    assign result_out.valid         = out_valid_reg;
    assign result_out.group_ordinal = out_ord_reg;
    assign result_out.member_thread = out_mem_reg;
    assign result_out.last_member   = out_last_reg;

    assign n_eff    = (32'(threads_reg) > MAX_THREADS) ? CNT_W'(MAX_THREADS)
                                                        : CNT_W'(threads_reg);
    assign tgt_eff  = (target_reg == '0) ? 32'd1 : 32'(target_reg);
    assign tot_size = 32'(size_a_reg) + 32'(size_b_reg);
    assign acc_new  = mode_reg ? ((ACC_W'(rate_rd) > acc_reg) ? ACC_W'(rate_rd) : acc_reg)
                               : acc_reg + ACC_W'(rate_rd);

    always_comb
    begin
        first_found = 1'b0;
        first_idx   = '0;
        high_idx    = '0;
        for (int s = MAX_THREADS - 1; s >= 0; s--)
        begin
            if (valid_reg[s])
            begin
                first_found = 1'b1;
                first_idx   = IDX_W'(s);
            end
        end
        for (int s = 0; s < MAX_THREADS; s++)
        begin
            if (valid_reg[s])
                high_idx = IDX_W'(s);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
            rate_mem[rate_wa] <= rate_wd;
        rate_rd <= rate_mem[rate_ra];
    end

    always_ff @(posedge clk)
    begin
        if (memb_we)
            memb_mem[memb_wa] <= memb_wd;
        memb_rd0 <= memb_mem[memb_ra0];
        memb_rd1 <= memb_mem[memb_ra1];
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        vg_next        = vg_reg;
        reuse_cnt_next = reuse_cnt_reg;
        valid_next     = valid_reg;
        reuse_next     = reuse_reg;
        size_next      = size_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_g_next    = last_g_reg;
        size_a_next    = size_a_reg;
        size_k_next    = size_k_reg;
        size_b_next    = size_b_reg;
        ord_next       = ord_reg;
        acc_next       = acc_reg;
        best_next      = best_reg;
        got_b_next     = got_b_reg;
        out_valid_next = out_valid_reg;
        out_ord_next   = out_ord_reg;
        out_mem_next   = out_mem_reg;
        out_last_next  = out_last_reg;
        rate_we        = 1'b0;
        rate_wa        = AW'(item_in.row_thread) * AW'(MAX_THREADS) + AW'(item_in.col_thread);
        rate_wd        = RATE_BITS'(item_in.rate_value);
        rate_ra        = AW'(memb_rd0) * AW'(MAX_THREADS) + AW'(memb_rd1);
        memb_we        = 1'b0;
        memb_wa        = '0;
        memb_wd        = '0;
        memb_ra0       = AW'(a_reg) * AW'(MAX_THREADS) + AW'(i_reg);
        memb_ra1       = AW'(k_reg) * AW'(MAX_THREADS) + AW'(j_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_in.valid)
                begin
                    if (item_in.command == CMD_WRITE)
                    begin
                        rate_we = (32'(item_in.row_thread) < MAX_THREADS) &&
                                  (32'(item_in.col_thread) < MAX_THREADS);
                    end
                    else
                    begin
                        n_next         = n_eff;
                        vg_next        = n_eff;
                        reuse_cnt_next = '0;
                        reuse_next     = '0;
                        i_next         = '0;
                        for (int s = 0; s < MAX_THREADS; s++)
                        begin
                            valid_next[s] = (32'(s) < 32'(n_eff));
                            size_next[s]  = (32'(s) < 32'(n_eff)) ? CNT_W'(1) : '0;
                        end
                        state_next = (n_eff == '0) ? S_ROUND : S_INIT;
                    end
                end
            end
            S_INIT:
            begin
                memb_we = 1'b1;
                memb_wa = AW'(i_reg[IDX_W-1:0]) * AW'(MAX_THREADS);
                memb_wd = i_reg[IDX_W-1:0];
                i_next  = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                    state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (32'(vg_reg) > tgt_eff)
                    state_next = S_PICK;
                else
                begin
                    k_next      = '0;
                    ord_next    = '0;
                    last_g_next = high_idx;
                    state_next  = S_OUT_NEXT;
                end
            end
            S_PICK:
            begin
                if (vg_reg == '0)
                    state_next = S_REVIVE;
                else if (!first_found)
                begin
                    vg_next    = '0;
                    state_next = S_REVIVE;
                end
                else
                begin
                    a_next      = first_idx;
                    size_a_next = size_reg[first_idx];
                    k_next      = '0;
                    got_b_next  = 1'b0;
                    best_next   = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (k_reg == n_reg)
                    state_next = S_MERGE;
                else if (k_reg[IDX_W-1:0] != a_reg && valid_reg[k_reg[IDX_W-1:0]])
                begin
                    size_k_next = size_reg[k_reg[IDX_W-1:0]];
                    i_next      = '0;
                    j_next      = '0;
                    acc_next    = '0;
                    state_next  = S_AFF_RD;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_AFF_RD:
                state_next = S_AFF_RT;
            S_AFF_RT:
                state_next = S_AFF_ACC;
            S_AFF_ACC:
            begin
                acc_next = acc_new;
                if (j_reg + 1'b1 < size_k_reg)
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_AFF_RD;
                end
                else if (i_reg + 1'b1 < size_a_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    j_next     = '0;
                    state_next = S_AFF_RD;
                end
                else
                begin
                    if (!got_b_reg || acc_new > best_reg)
                    begin
                        best_next   = acc_new;
                        b_next      = k_reg[IDX_W-1:0];
                        size_b_next = size_k_reg;
                        got_b_next  = 1'b1;
                    end
                    k_next     = k_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_MERGE:
            begin
                if (!got_b_reg)
                begin
                    // lone leftover carries over to the next round
                    valid_next[a_reg] = 1'b0;
                    reuse_next[a_reg] = 1'b1;
                    vg_next           = vg_reg - 1'b1;
                    reuse_cnt_next    = reuse_cnt_reg + 1'b1;
                    state_next        = S_PICK;
                end
                else
                begin
                    i_next     = '0;
                    state_next = (32'(size_a_reg) < MAX_THREADS) ? S_CP_RD : S_MFIN;
                end
            end
            S_CP_RD:
            begin
                memb_ra0   = AW'(b_reg) * AW'(MAX_THREADS) + AW'(i_reg);
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                memb_we = 1'b1;
                memb_wa = AW'(a_reg) * AW'(MAX_THREADS) + AW'(size_a_reg) + AW'(i_reg);
                memb_wd = memb_rd0;
                i_next  = i_reg + 1'b1;
                if ((32'(i_reg) + 1 < 32'(size_b_reg)) &&
                    (32'(size_a_reg) + 32'(i_reg) + 1 < MAX_THREADS))
                    state_next = S_CP_RD;
                else
                    state_next = S_MFIN;
            end
            S_MFIN:
            begin
                size_next[a_reg]  = (tot_size > MAX_THREADS) ? CNT_W'(MAX_THREADS)
                                                             : CNT_W'(tot_size);
                size_next[b_reg]  = '0;
                valid_next[a_reg] = 1'b0;
                valid_next[b_reg] = 1'b0;
                reuse_next[a_reg] = 1'b1;
                vg_next           = (vg_reg >= CNT_W'(2)) ? vg_reg - CNT_W'(2) : '0;
                reuse_cnt_next    = reuse_cnt_reg + 1'b1;
                state_next        = S_PICK;
            end
            S_REVIVE:
            begin
                valid_next     = valid_reg | reuse_reg;
                reuse_next     = '0;
                vg_next        = vg_reg + reuse_cnt_reg;
                reuse_cnt_next = '0;
                state_next     = S_ROUND;
            end
            S_OUT_NEXT:
            begin
                if (k_reg == n_reg)
                    state_next = S_IDLE;
                else if (valid_reg[k_reg[IDX_W-1:0]])
                begin
                    i_next      = '0;
                    size_k_next = size_reg[k_reg[IDX_W-1:0]];
                    state_next  = S_OUT_RD;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            S_OUT_RD:
            begin
                memb_ra0   = AW'(k_reg) * AW'(MAX_THREADS) + AW'(i_reg);
                state_next = S_OUT_LOAD;
            end
            S_OUT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_ord_next   = THR_W'(ord_reg);
                out_mem_next   = THR_W'(memb_rd0);
                out_last_next  = (i_reg + 1'b1 == size_k_reg) &&
                                 (k_reg[IDX_W-1:0] == last_g_reg);
                state_next     = S_OUT_WAIT;
            end
            S_OUT_WAIT:
            begin
                if (result_out.ready)
                begin
                    out_valid_next = 1'b0;
                    if (i_reg + 1'b1 < size_k_reg)
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        ord_next   = ord_reg + 1'b1;
                        state_next = S_OUT_NEXT;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= cfg_t'(2);
            threads_reg   <= cfg_t'(32);
            mode_reg      <= 1'b0;
            state_reg     <= S_IDLE;
            n_reg         <= '0;
            vg_reg        <= '0;
            reuse_cnt_reg <= '0;
            valid_reg     <= '0;
            reuse_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < MAX_THREADS; s++)
                size_reg[s] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TARGET:  target_reg  <= cfg_data;
                    REG_THREADS: threads_reg <= cfg_data;
                    REG_MODE:    mode_reg    <= cfg_data[0];
                    default:     ;
                endcase
            end
            state_reg     <= state_next;
            n_reg         <= n_next;
            vg_reg        <= vg_next;
            reuse_cnt_reg <= reuse_cnt_next;
            valid_reg     <= valid_next;
            reuse_reg     <= reuse_next;
            out_valid_reg <= out_valid_next;
            size_reg      <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_g_reg   <= last_g_next;
        size_a_reg   <= size_a_next;
        size_k_reg   <= size_k_next;
        size_b_reg   <= size_b_next;
        ord_reg      <= ord_next;
        acc_reg      <= acc_next;
        best_reg     <= best_next;
        got_b_reg    <= got_b_next;
        out_ord_reg  <= out_ord_next;
        out_mem_reg  <= out_mem_next;
        out_last_reg <= out_last_next;
    end

    a_vg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vg_reg <= n_reg)
        else $error("valid group count above thread count");

    a_flags_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & reuse_reg) == '0)
        else $error("slot both valid and parked");

    a_reuse_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(reuse_reg) == 32'(reuse_cnt_reg))
        else $error("parked count out of step with parked flags");

    a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (state_reg == S_OUT_WAIT))
        else $error("result word shown outside output wait");
endmodule
